// ===== sv/ltpe_pkg.sv =====
// Package for the link transfer protocol engine: protocol bytes, commands,
// result-sequence codes and the request struct passed from front to back.
// No dependencies.
package ltpe_pkg;

    localparam logic [7:0] C_SOH = 8'h01;
    localparam logic [7:0] C_STX = 8'h02;
    localparam logic [7:0] C_ETX = 8'h03;
    localparam logic [7:0] C_EOT = 8'h04;
    localparam logic [7:0] C_ENQ = 8'h05;
    localparam logic [7:0] C_ACK = 8'h06;
    localparam logic [7:0] C_ETB = 8'h17;
    localparam logic [7:0] C_N   = 8'h4E;
    localparam logic [7:0] C_ZERO = 8'h30;
    localparam logic [7:0] C_EIGHT = 8'h38;
    localparam logic [7:0] C_ONE = 8'h31;
    localparam logic [7:0] C_ID_OFS = 8'h20;
    localparam logic [7:0] C_HEX_ALPHA = 8'h37;

    localparam logic [2:0] CMD_WRITE = 3'd0;
    localparam logic [2:0] CMD_READ  = 3'd1;
    localparam logic [2:0] CMD_RX    = 3'd2;
    localparam logic [2:0] CMD_TICK  = 3'd3;
    localparam logic [2:0] CMD_DATA  = 3'd4;

    localparam logic [1:0] CFG_TARGET  = 2'd0;
    localparam logic [1:0] CFG_SOURCE  = 2'd1;
    localparam logic [1:0] CFG_TIMEOUT = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_PROTO   = 2'd1;
    localparam logic [1:0] ST_TIMEOUT = 2'd2;

    // kind of result sequence the back end expands
    typedef enum logic [2:0] {
        SEQ_BYTES  = 3'd0,  // up to three listed tx bytes
        SEQ_HEADER = 3'd1,  // 17-byte header
        SEQ_HDR_STX = 3'd2, // expanded by the back end as the 17-byte header only
        SEQ_RX     = 3'd3,  // one received payload byte
        SEQ_DONE   = 3'd4,  // done with status, no bytes
        SEQ_TX_DONE = 3'd5  // one tx byte then done
    } seq_kind_t;

    typedef struct packed {
        seq_kind_t   kind;
        logic [1:0]  nbytes;
        logic [7:0]  b0;
        logic [7:0]  b1;
        logic [7:0]  b2;
        logic [1:0]  status;
        logic [15:0] address;
        logic [15:0] count;
        logic [3:0]  target;
        logic [3:0]  source;
        logic        is_read;
    } req_t;

    function automatic logic [7:0] hex_digit(input logic [3:0] v);
        return (v < 4'd10) ? (C_ZERO + {4'd0, v}) : (C_HEX_ALPHA + {4'd0, v});
    endfunction

endpackage

// ===== sv/ltpe_front.sv =====
// Front end: accepts commands, runs the protocol state and emits one request
// per command that has results.
// Depends on ltpe_pkg.
module ltpe_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               push,
    output logic               full,
    input  logic [2:0]         command,
    input  logic [15:0]        target_address,
    input  logic [15:0]        byte_count,
    input  logic [7:0]         data_byte,
    output logic               req_valid,
    input  logic               req_ready,
    output ltpe_pkg::req_t     req
);
    import ltpe_pkg::*;

    typedef enum logic [6:0] {
        PH_IDLE     = 7'b0000001,
        PH_TID      = 7'b0000010,
        PH_HDR_ACK  = 7'b0000100,
        PH_WR_DATA  = 7'b0001000,
        PH_WR_ACK   = 7'b0010000,
        PH_RD_FRAME = 7'b0100000,
        PH_RD_EOT   = 7'b1000000
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic        is_read_reg, is_read_next;
    logic [15:0] address_reg, address_next;
    logic [15:0] count_reg, count_next;
    logic [7:0]  blocks_reg, blocks_next;
    logic [8:0]  pos_reg, pos_next;
    logic [7:0]  lrc_reg, lrc_next;
    logic        err_reg, err_next;
    logic [15:0] tmo_reg, tmo_next;
    logic [3:0]  target_reg;
    logic [3:0]  source_reg;
    logic [15:0] timeout_reg;

    logic        emit;
    req_t        r;
    logic        accept;
    logic [8:0]  dlen;
    logic [7:0]  tid_byte;
    logic [7:0]  lrc_upd;
    logic [8:0]  pos_inc;

    assign full   = req_valid && !req_ready;
    assign accept = push && !full;
    assign dlen   = (blocks_reg != 8'd0) ? 9'd256 : {1'b0, count_reg[7:0]};
    assign tid_byte = {4'd0, target_reg} + C_ID_OFS;
    assign lrc_upd  = lrc_reg ^ data_byte;
    assign pos_inc  = pos_reg + 9'd1;

    always_comb
    begin
        phase_next   = phase_reg;
        is_read_next = is_read_reg;
        address_next = address_reg;
        count_next   = count_reg;
        blocks_next  = blocks_reg;
        pos_next     = pos_reg;
        lrc_next     = lrc_reg;
        err_next     = err_reg;
        tmo_next     = tmo_reg;
        emit         = 1'b0;
        r            = '0;
        r.kind       = SEQ_BYTES;
        r.target     = target_reg;
        r.source     = source_reg;
        r.address    = address_reg;
        r.count      = count_reg;
        r.is_read    = is_read_reg;
        case (command)
            CMD_WRITE, CMD_READ:
            begin
                if (phase_reg == PH_IDLE)
                begin
                    is_read_next = command[0];
                    address_next = target_address;
                    count_next   = byte_count;
                    blocks_next  = byte_count[15:8];
                    pos_next     = '0;
                    lrc_next     = '0;
                    err_next     = 1'b0;
                    tmo_next     = '0;
                    phase_next   = PH_TID;
                    emit     = 1'b1;
                    r.nbytes = 2'd3;
                    r.b0     = C_N;
                    r.b1     = tid_byte;
                    r.b2     = C_ENQ;
                end
            end
            CMD_RX:
            begin
                case (phase_reg)
                    PH_TID:
                    begin
                        if (data_byte != ((pos_reg == 9'd0) ? C_N :
                                          (pos_reg == 9'd1) ? tid_byte : C_ACK))
                        begin
                            err_next = 1'b1;
                        end
                        if (pos_reg >= 9'd2)
                        begin
                            emit = 1'b1;
                            if (err_next)
                            begin
                                r.kind = SEQ_DONE;
                                r.status = ST_PROTO;
                                phase_next = PH_IDLE;
                            end
                            else
                            begin
                                r.kind = SEQ_HEADER;
                                phase_next = PH_HDR_ACK;
                                tmo_next = '0;
                            end
                        end
                        else
                        begin
                            pos_next = pos_inc;
                        end
                    end
                    PH_HDR_ACK, PH_WR_ACK:
                    begin
                        emit = 1'b1;
                        if (data_byte != C_ACK)
                        begin
                            r.kind = SEQ_DONE;
                            r.status = ST_PROTO;
                            phase_next = PH_IDLE;
                        end
                        else if (phase_reg == PH_HDR_ACK && is_read_reg)
                        begin
                            emit = 1'b0;
                            pos_next = '0;
                            lrc_next = '0;
                            err_next = 1'b0;
                            tmo_next = '0;
                            phase_next = PH_RD_FRAME;
                        end
                        else if (phase_reg == PH_WR_ACK && blocks_reg == 8'd0)
                        begin
                            r.kind = SEQ_TX_DONE;
                            r.b0 = C_EOT;
                            r.status = ST_OK;
                            phase_next = PH_IDLE;
                        end
                        else
                        begin
                            if (phase_reg == PH_WR_ACK)
                            begin
                                blocks_next = blocks_reg - 8'd1;
                            end
                            pos_next = '0;
                            lrc_next = '0;
                            phase_next = PH_WR_DATA;
                            r.b0 = C_STX;
                            r.b1 = C_ETX;
                            r.b2 = 8'h00;
                            r.nbytes = 2'd1;
                            if (blocks_next == 8'd0 && count_reg[7:0] == 8'd0)
                            begin
                                r.nbytes = 2'd3;
                                phase_next = PH_WR_ACK;
                                tmo_next = '0;
                            end
                        end
                    end
                    PH_RD_FRAME:
                    begin
                        if (pos_reg == 9'd0)
                        begin
                            if (data_byte != C_STX)
                            begin
                                err_next = 1'b1;
                            end
                            pos_next = pos_inc;
                        end
                        else if (pos_reg <= dlen)
                        begin
                            lrc_next = lrc_upd;
                            pos_next = pos_inc;
                            if (!err_reg)
                            begin
                                emit = 1'b1;
                                r.kind = SEQ_RX;
                                r.b0 = data_byte;
                            end
                        end
                        else if (pos_reg == dlen + 9'd1)
                        begin
                            if (data_byte != ((blocks_reg != 8'd0) ? C_ETB : C_ETX))
                            begin
                                err_next = 1'b1;
                            end
                            pos_next = pos_inc;
                        end
                        else
                        begin
                            emit = 1'b1;
                            if (err_reg || data_byte != lrc_reg)
                            begin
                                r.kind = SEQ_DONE;
                                r.status = ST_PROTO;
                                phase_next = PH_IDLE;
                            end
                            else
                            begin
                                r.nbytes = 2'd1;
                                r.b0 = C_ACK;
                                tmo_next = '0;
                                if (blocks_reg != 8'd0)
                                begin
                                    blocks_next = blocks_reg - 8'd1;
                                    pos_next = '0;
                                    lrc_next = '0;
                                    err_next = 1'b0;
                                end
                                else
                                begin
                                    phase_next = PH_RD_EOT;
                                end
                            end
                        end
                    end
                    PH_RD_EOT:
                    begin
                        emit = 1'b1;
                        phase_next = PH_IDLE;
                        if (data_byte != C_EOT)
                        begin
                            r.kind = SEQ_DONE;
                            r.status = ST_PROTO;
                        end
                        else
                        begin
                            r.kind = SEQ_TX_DONE;
                            r.b0 = C_EOT;
                            r.status = ST_OK;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            CMD_TICK:
            begin
                if (phase_reg != PH_IDLE && phase_reg != PH_WR_DATA)
                begin
                    if (tmo_reg != 16'hFFFF)
                    begin
                        tmo_next = tmo_reg + 16'd1;
                    end
                    if (tmo_next >= timeout_reg)
                    begin
                        emit = 1'b1;
                        r.kind = SEQ_DONE;
                        r.status = ST_TIMEOUT;
                        phase_next = PH_IDLE;
                    end
                end
            end
            CMD_DATA:
            begin
                if (phase_reg == PH_WR_DATA)
                begin
                    emit = 1'b1;
                    r.nbytes = 2'd1;
                    r.b0 = data_byte;
                    lrc_next = lrc_upd;
                    pos_next = pos_inc;
                    if (pos_inc >= dlen)
                    begin
                        r.nbytes = 2'd3;
                        r.b1 = (blocks_reg != 8'd0) ? C_ETB : C_ETX;
                        r.b2 = lrc_upd;
                        phase_next = PH_WR_ACK;
                        tmo_next = '0;
                    end
                end
            end
            default:
            begin
            end
        endcase
        // a header followed by STX cannot arise; kept in kinds for the back end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            is_read_reg <= 1'b0;
            address_reg <= '0;
            count_reg   <= '0;
            blocks_reg  <= '0;
            pos_reg     <= '0;
            lrc_reg     <= '0;
            err_reg     <= 1'b0;
            tmo_reg     <= '0;
            req_valid   <= 1'b0;
            target_reg  <= '0;
            source_reg  <= '0;
            timeout_reg <= 16'd300;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_TARGET:  target_reg  <= cfg_data[3:0];
                    CFG_SOURCE:  source_reg  <= cfg_data[3:0];
                    CFG_TIMEOUT: timeout_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            if (req_valid && req_ready)
            begin
                req_valid <= 1'b0;
            end
            if (accept)
            begin
                phase_reg   <= phase_next;
                is_read_reg <= is_read_next;
                address_reg <= address_next;
                count_reg   <= count_next;
                blocks_reg  <= blocks_next;
                pos_reg     <= pos_next;
                lrc_reg     <= lrc_next;
                err_reg     <= err_next;
                tmo_reg     <= tmo_next;
                if (emit)
                begin
                    req_valid <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            req <= r;
        end
    end

    property p_idle_after_done;
        @(posedge clk) disable iff (!rst_n)
        (accept && emit && r.kind == SEQ_DONE) |=> (phase_reg == PH_IDLE);
    endproperty
    a_idle_after_done: assert property (p_idle_after_done)
        else $error("phase not idle after done");

    property p_no_overwrite;
        @(posedge clk) disable iff (!rst_n)
        (req_valid && !req_ready) |=> (req_valid && $stable(req));
    endproperty
    a_no_overwrite: assert property (p_no_overwrite)
        else $error("pending request overwritten");

    property p_pos_bound;
        @(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_TID) |-> (pos_reg <= 9'd2);
    endproperty
    a_pos_bound: assert property (p_pos_bound)
        else $error("reply position out of range");

endmodule

// ===== sv/ltpe_back.sv =====
// Back end: expands each request into result items for the output queue.
// Depends on ltpe_pkg.
module ltpe_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  ltpe_pkg::req_t req,
    output logic           empty,
    input  logic           pop,
    output logic           tx_valid,
    output logic [7:0]     tx_byte,
    output logic           rx_valid,
    output logic [7:0]     rx_byte,
    output logic           done_res,
    output logic [1:0]     status,
    output logic           last
);
    import ltpe_pkg::*;

    logic        busy_reg;
    req_t        cur_reg;
    logic [4:0]  idx_reg;
    logic [4:0]  total;
    logic [7:0]  hdr [17];
    logic [7:0]  hdr_x;
    logic        out_v_reg;
    logic        o_txv, o_rxv, o_dn, o_last;
    logic [7:0]  o_b;
    logic [1:0]  o_st;
    logic        adv;
    logic        load;

    always_comb
    begin
        hdr[0]  = C_SOH;
        hdr[1]  = C_ZERO;
        hdr[2]  = C_ZERO + {4'd0, cur_reg.target};
        hdr[3]  = cur_reg.is_read ? C_ZERO : C_EIGHT;
        hdr[4]  = C_ONE;
        hdr[5]  = hex_digit(cur_reg.address[15:12]);
        hdr[6]  = hex_digit(cur_reg.address[11:8]);
        hdr[7]  = hex_digit(cur_reg.address[7:4]);
        hdr[8]  = hex_digit(cur_reg.address[3:0]);
        hdr[9]  = hex_digit(cur_reg.count[15:12]);
        hdr[10] = hex_digit(cur_reg.count[11:8]);
        hdr[11] = hex_digit(cur_reg.count[7:4]);
        hdr[12] = hex_digit(cur_reg.count[3:0]);
        hdr[13] = C_ZERO;
        hdr[14] = C_ZERO + {4'd0, cur_reg.source};
        hdr[15] = C_ETB;
        hdr_x = '0;
        for (int i = 1; i < 15; i++)
        begin
            hdr_x = hdr_x ^ hdr[i];
        end
        hdr[16] = hdr_x;
    end

    always_comb
    begin
        o_txv = 1'b0;
        o_rxv = 1'b0;
        o_dn  = 1'b0;
        o_b   = '0;
        o_st  = '0;
        total = 5'd1;
        case (cur_reg.kind)
            SEQ_BYTES:
            begin
                total = {3'd0, cur_reg.nbytes};
                o_txv = 1'b1;
                o_b = (idx_reg == 5'd0) ? cur_reg.b0 :
                      (idx_reg == 5'd1) ? cur_reg.b1 : cur_reg.b2;
            end
            SEQ_HEADER, SEQ_HDR_STX:
            begin
                total = 5'd17;
                o_txv = 1'b1;
                o_b = hdr[idx_reg];
            end
            SEQ_RX:
            begin
                o_rxv = 1'b1;
                o_b = cur_reg.b0;
            end
            SEQ_DONE:
            begin
                o_dn = 1'b1;
                o_st = cur_reg.status;
            end
            SEQ_TX_DONE:
            begin
                total = 5'd2;
                if (idx_reg == 5'd0)
                begin
                    o_txv = 1'b1;
                    o_b = cur_reg.b0;
                end
                else
                begin
                    o_dn = 1'b1;
                    o_st = cur_reg.status;
                end
            end
            default:
            begin
            end
        endcase
        o_last = (idx_reg + 5'd1 == total);
    end

    assign adv       = busy_reg && (!out_v_reg || pop);
    assign load      = !busy_reg || (adv && o_last);
    assign req_ready = load;
    assign empty     = !out_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            idx_reg   <= '0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (pop && out_v_reg)
            begin
                out_v_reg <= 1'b0;
            end
            if (adv)
            begin
                out_v_reg <= 1'b1;
                idx_reg <= idx_reg + 5'd1;
            end
            if (load)
            begin
                busy_reg <= req_valid;
                idx_reg  <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && req_valid)
        begin
            cur_reg <= req;
        end
        if (adv)
        begin
            tx_valid <= o_txv;
            rx_valid <= o_rxv;
            tx_byte  <= o_txv ? o_b : 8'd0;
            rx_byte  <= o_rxv ? o_b : 8'd0;
            done_res <= o_dn;
            status   <= o_st;
            last     <= o_last;
        end
    end

    property p_hold_out;
        @(posedge clk) disable iff (!rst_n)
        (out_v_reg && !pop) |=> (out_v_reg && $stable(tx_byte) && $stable(last));
    endproperty
    a_hold_out: assert property (p_hold_out)
        else $error("result changed while waiting");

    property p_idx_range;
        @(posedge clk) disable iff (!rst_n)
        busy_reg |-> (idx_reg < 5'd17);
    endproperty
    a_idx_range: assert property (p_idx_range)
        else $error("sequence index out of range");

    property p_one_kind;
        @(posedge clk) disable iff (!rst_n)
        out_v_reg |-> $onehot0({tx_valid, rx_valid, done_res});
    endproperty
    a_one_kind: assert property (p_one_kind)
        else $error("result carries more than one kind");

endmodule

// ===== sv/link_transfer_protocol_engine_core.sv =====
// Link transfer protocol engine, master side.
// Path: front request register, back-end sequence register, output register.
// Throughput: one command per cycle; a command with n results holds the back end
// for all n (header: 17), and input stalls once the single request slot is full.
// Reset: asynchronous, active low; idle phase, empty queue, reply_timeout 300.
module link_transfer_protocol_engine_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        push,
    output logic        full,
    input  logic [2:0]  command,
    input  logic [15:0] target_address,
    input  logic [15:0] byte_count,
    input  logic [7:0]  data_byte,
    output logic        empty,
    input  logic        pop,
    output logic        tx_valid,
    output logic [7:0]  tx_byte,
    output logic        rx_valid,
    output logic [7:0]  rx_byte,
    output logic        done_res,
    output logic [1:0]  status,
    output logic        last
);
    import ltpe_pkg::*;

    logic req_valid;
    logic req_ready;
    req_t req;

    ltpe_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .push           (push),
        .full           (full),
        .command        (command),
        .target_address (target_address),
        .byte_count     (byte_count),
        .data_byte      (data_byte),
        .req_valid      (req_valid),
        .req_ready      (req_ready),
        .req            (req)
    );

    ltpe_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .empty     (empty),
        .pop       (pop),
        .tx_valid  (tx_valid),
        .tx_byte   (tx_byte),
        .rx_valid  (rx_valid),
        .rx_byte   (rx_byte),
        .done_res  (done_res),
        .status    (status),
        .last      (last)
    );

endmodule

// ===== verif/link_transfer_protocol_engine_core_tb.sv =====
// Testbench for link_transfer_protocol_engine_core: drives link transfer requests
// through the queue ports and checks every result against an in-bench predictor.
// Depends on ltpe_pkg and the core RTL.
`timescale 1ns / 100ps

module link_transfer_protocol_engine_core_tb;
    import ltpe_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;

    typedef enum logic [3:0] {
        P_IDLE, P_TID, P_HDR_ACK, P_WR_DATA, P_WR_ACK, P_RD_FRAME, P_RD_EOT
    } xfer_phase_t;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [15:0] addr;
        logic [15:0] cnt;
        logic [7:0]  dbyte;
    } link_req_t;

    typedef struct packed {
        logic       txv;
        logic [7:0] txb;
        logic       rxv;
        logic [7:0] rxb;
        logic       dn;
        logic [1:0] st;
        logic       lst;
    } link_res_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        push;
    logic        full;
    logic [2:0]  command;
    logic [15:0] target_address;
    logic [15:0] byte_count;
    logic [7:0]  data_byte;
    logic        empty;
    logic        pop;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        rx_valid;
    logic [7:0]  rx_byte;
    logic        done_res;
    logic [1:0]  status;
    logic        last;

    link_transfer_protocol_engine_core uut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .push(push), .full(full),
        .command(command), .target_address(target_address),
        .byte_count(byte_count), .data_byte(data_byte),
        .empty(empty), .pop(pop),
        .tx_valid(tx_valid), .tx_byte(tx_byte), .rx_valid(rx_valid),
        .rx_byte(rx_byte), .done_res(done_res), .status(status), .last(last)
    );

    link_req_t   pending_reqs[$];
    link_res_t   expected_res[$];
    link_res_t   step_res[$];
    int          errors = 0;
    int          cycles = 0;
    int          gap_pct = 0;
    int          stall_pct = 0;

    // predictor state and configuration copy
    logic [3:0]  tid_cfg;
    logic [3:0]  sid_cfg;
    logic [15:0] tmo_lim;
    xfer_phase_t ph;
    logic        rd_q;
    logic [15:0] addr_q;
    logic [15:0] cnt_q;
    logic [7:0]  blocks_left;
    logic [8:0]  fpos;
    logic [7:0]  lrc;
    logic        ferr;
    logic [15:0] tmo_cnt;

    task automatic report(input string msg);
        $display("mismatch @%0d: %s", cycles, msg);
        errors++;
    endtask

    task automatic emit(input logic txv, input logic [7:0] txb, input logic rxv,
                        input logic [7:0] rxb, input logic dn, input logic [1:0] st);
        step_res.push_back('{txv, txb, rxv, rxb, dn, st, 1'b0});
    endtask

    task automatic send_byte(input logic [7:0] b);
        emit(1'b1, b, 1'b0, 8'h00, 1'b0, ST_OK);
    endtask

    task automatic end_transfer(input logic [1:0] st);
        emit(1'b0, 8'h00, 1'b0, 8'h00, 1'b1, st);
        ph = P_IDLE;
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        return (v < 4'd10) ? 8'h30 + v : 8'h37 + v;
    endfunction

    function automatic logic [8:0] block_len();
        return (blocks_left != 0) ? 9'd256 : {1'b0, cnt_q[7:0]};
    endfunction

    task automatic send_header();
        logic [7:0] h[17];
        logic [7:0] x;
        x = 8'h00;
        h[0] = C_SOH; h[1] = C_ZERO; h[2] = C_ZERO + tid_cfg;
        h[3] = rd_q ? C_ZERO : C_EIGHT; h[4] = C_ONE;
        for (int i = 0; i < 4; i++)
        begin
            h[5 + i] = hex_char(addr_q[15 - 4 * i -: 4]);
            h[9 + i] = hex_char(cnt_q[15 - 4 * i -: 4]);
        end
        h[13] = C_ZERO; h[14] = C_ZERO + sid_cfg; h[15] = C_ETB;
        for (int i = 1; i < 15; i++) x ^= h[i];
        h[16] = x;
        for (int i = 0; i < 17; i++) send_byte(h[i]);
    endtask

    task automatic open_write_block();
        send_byte(C_STX);
        fpos = 0; lrc = 0; ph = P_WR_DATA;
        if (block_len() == 0)
        begin
            send_byte(C_ETX); send_byte(8'h00);
            ph = P_WR_ACK; tmo_cnt = 0;
        end
    endtask

    task automatic open_read_frame();
        fpos = 0; lrc = 0; ferr = 0; tmo_cnt = 0; ph = P_RD_FRAME;
    endtask

    task automatic link_byte_in(input logic [7:0] b);
        logic [7:0] want;
        logic [8:0] dlen;
        case (ph)
            P_TID:
            begin
                want = (fpos == 0) ? C_N : (fpos == 1) ? C_ID_OFS + tid_cfg : C_ACK;
                if (b != want) ferr = 1;
                if (fpos >= 2)
                begin
                    if (ferr) end_transfer(ST_PROTO);
                    else
                    begin
                        send_header();
                        ph = P_HDR_ACK; tmo_cnt = 0;
                    end
                end
                else fpos++;
            end
            P_HDR_ACK:
            begin
                if (b != C_ACK) end_transfer(ST_PROTO);
                else if (rd_q) open_read_frame();
                else open_write_block();
            end
            P_WR_ACK:
            begin
                if (b != C_ACK) end_transfer(ST_PROTO);
                else if (blocks_left != 0)
                begin
                    blocks_left--;
                    open_write_block();
                end
                else
                begin
                    send_byte(C_EOT);
                    end_transfer(ST_OK);
                end
            end
            P_RD_FRAME:
            begin
                dlen = block_len();
                if (fpos == 0)
                begin
                    if (b != C_STX) ferr = 1;
                    fpos++;
                end
                else if (fpos <= dlen)
                begin
                    lrc ^= b;
                    if (!ferr) emit(1'b0, 8'h00, 1'b1, b, 1'b0, ST_OK);
                    fpos++;
                end
                else if (fpos == dlen + 1)
                begin
                    if (b != ((blocks_left != 0) ? C_ETB : C_ETX)) ferr = 1;
                    fpos++;
                end
                else if (ferr || b != lrc) end_transfer(ST_PROTO);
                else
                begin
                    send_byte(C_ACK);
                    if (blocks_left != 0)
                    begin
                        blocks_left--;
                        open_read_frame();
                    end
                    else
                    begin
                        ph = P_RD_EOT; tmo_cnt = 0;
                    end
                end
            end
            P_RD_EOT:
            begin
                if (b != C_EOT) end_transfer(ST_PROTO);
                else
                begin
                    send_byte(C_EOT);
                    end_transfer(ST_OK);
                end
            end
            default: ;
        endcase
    endtask

    task automatic predict_request(input link_req_t r);
        step_res.delete();
        case (r.cmd)
            CMD_WRITE, CMD_READ:
            if (ph == P_IDLE)
            begin
                rd_q = (r.cmd == CMD_READ);
                addr_q = r.addr; cnt_q = r.cnt;
                blocks_left = r.cnt[15:8];
                fpos = 0; lrc = 0; ferr = 0; tmo_cnt = 0;
                send_byte(C_N); send_byte(C_ID_OFS + tid_cfg); send_byte(C_ENQ);
                ph = P_TID;
            end
            CMD_RX: link_byte_in(r.dbyte);
            CMD_TICK:
            if (ph inside {P_TID, P_HDR_ACK, P_WR_ACK, P_RD_FRAME, P_RD_EOT})
            begin
                if (tmo_cnt != 16'hFFFF) tmo_cnt++;
                if (tmo_cnt >= tmo_lim) end_transfer(ST_TIMEOUT);
            end
            CMD_DATA:
            if (ph == P_WR_DATA)
            begin
                send_byte(r.dbyte);
                lrc ^= r.dbyte;
                fpos++;
                if (fpos >= block_len())
                begin
                    send_byte((blocks_left != 0) ? C_ETB : C_ETX);
                    send_byte(lrc);
                    ph = P_WR_ACK; tmo_cnt = 0;
                end
            end
            default: ;
        endcase
        if (step_res.size() > 0) step_res[step_res.size() - 1].lst = 1'b1;
        foreach (step_res[i]) expected_res.push_back(step_res[i]);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push <= 1'b0;
            command <= CMD_TICK;
            target_address <= '0;
            byte_count <= '0;
            data_byte <= '0;
        end
        else
        begin
            if (push && !full)
            begin
                predict_request(pending_reqs[0]);
                void'(pending_reqs.pop_front());
            end
            if (pending_reqs.size() > 0 && $urandom_range(99) >= gap_pct)
            begin
                push <= 1'b1;
                command <= pending_reqs[0].cmd;
                target_address <= pending_reqs[0].addr;
                byte_count <= pending_reqs[0].cnt;
                data_byte <= pending_reqs[0].dbyte;
            end
            else push <= 1'b0;
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        link_res_t got;
        link_res_t want;
        if (!rst_n) pop <= 1'b0;
        else
        begin
            if (pop && !empty)
            begin
                got = '{tx_valid, tx_byte, rx_valid, rx_byte, done_res, status, last};
                if (expected_res.size() == 0)
                    report($sformatf("unexpected result %h", got));
                else
                begin
                    want = expected_res.pop_front();
                    if (got !== want)
                        report($sformatf({"tx %b/%h rx %b/%h done %b st %0d last %b, ",
                                          "want tx %b/%h rx %b/%h done %b st %0d last %b"},
                            got.txv, got.txb, got.rxv, got.rxb, got.dn, got.st, got.lst,
                            want.txv, want.txb, want.rxv, want.rxb, want.dn, want.st,
                            want.lst));
                end
            end
            pop <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic drain();
        while (pending_reqs.size() != 0 || push || expected_res.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        if (idx == CFG_TARGET) tid_cfg = val[3:0];
        else if (idx == CFG_SOURCE) sid_cfg = val[3:0];
        else tmo_lim = val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic link_req_t mk(input logic [2:0] c, input logic [7:0] b);
        return '{c, 16'h0000, 16'h0000, b};
    endfunction

    // advance the block back to idle, by payload or by timeout
    task automatic settle();
        while (ph != P_IDLE)
        begin
            if (ph == P_WR_DATA)
                for (int i = fpos; i < block_len(); i++)
                    pending_reqs.push_back(mk(CMD_DATA, 8'($urandom_range(255))));
            else
                for (int i = 0; i <= tmo_lim; i++)
                    pending_reqs.push_back(mk(CMD_TICK, 8'($urandom_range(255))));
            drain();
        end
    endtask

    // fault: 0 clean, 1 corrupt at most one received link byte, 2 cut short, 3 noise mixed in
    task automatic run_transfer(input logic rd, input logic [15:0] addr,
                                input logic [15:0] cnt, input int fault);
        link_req_t seq[$];
        link_req_t n;
        logic [7:0] x;
        int nfull;
        int len;
        int k;
        nfull = cnt[15:8];
        seq.push_back('{rd ? CMD_READ : CMD_WRITE, addr, cnt, 8'($urandom_range(255))});
        seq.push_back(mk(CMD_RX, C_N));
        seq.push_back(mk(CMD_RX, C_ID_OFS + tid_cfg));
        seq.push_back(mk(CMD_RX, C_ACK));
        seq.push_back(mk(CMD_RX, C_ACK));
        for (int blk = 0; blk <= nfull; blk++)
        begin
            len = (blk < nfull) ? 256 : cnt[7:0];
            x = 8'h00;
            if (rd) seq.push_back(mk(CMD_RX, C_STX));
            for (int i = 0; i < len; i++)
            begin
                n = mk(rd ? CMD_RX : CMD_DATA, 8'($urandom_range(255)));
                x ^= n.dbyte;
                seq.push_back(n);
            end
            if (rd)
            begin
                seq.push_back(mk(CMD_RX, (blk < nfull) ? C_ETB : C_ETX));
                seq.push_back(mk(CMD_RX, x));
            end
            else seq.push_back(mk(CMD_RX, C_ACK));
        end
        if (rd) seq.push_back(mk(CMD_RX, C_EOT));
        if (fault == 1)
        begin
            k = $urandom_range(1, seq.size() - 1);
            if (seq[k].cmd == CMD_RX) seq[k].dbyte ^= 8'($urandom_range(1, 255));
        end
        else if (fault == 2)
        begin
            k = $urandom_range(1, seq.size() - 1);
            while (seq.size() > k) void'(seq.pop_back());
        end
        foreach (seq[i])
        begin
            if (fault == 3 && $urandom_range(99) < 8)
            begin
                k = $urandom_range(3);
                if (k == 0)
                    pending_reqs.push_back(mk(CMD_TICK, 8'($urandom_range(255))));
                else if (k == 1)
                    pending_reqs.push_back('{3'($urandom_range(1)),
                        16'($urandom_range(16'hFFFF)), 16'($urandom_range(16'hFFFF)),
                        8'($urandom_range(255))});
                else if (k == 2)
                    pending_reqs.push_back(mk(3'($urandom_range(5, 7)),
                        8'($urandom_range(255))));
                else if (rd)
                    pending_reqs.push_back(mk(CMD_DATA, 8'($urandom_range(255))));
            end
            pending_reqs.push_back(seq[i]);
        end
        drain();
        settle();
    endtask

    initial
    begin
        int txn;
        int mode;
        int cnt;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_TARGET;
        cfg_data = '0;
        tid_cfg = 0; sid_cfg = 0; tmo_lim = 16'd300;
        ph = P_IDLE; rd_q = 0; addr_q = 0; cnt_q = 0; blocks_left = 0;
        fpos = 0; lrc = 0; ferr = 0; tmo_cnt = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // ignored traffic while idle
        pending_reqs.push_back(mk(CMD_RX, C_ACK));
        pending_reqs.push_back(mk(CMD_DATA, 8'hFF));
        pending_reqs.push_back(mk(CMD_TICK, 8'h00));
        pending_reqs.push_back(mk(3'd5, 8'h00));
        pending_reqs.push_back(mk(3'd7, 8'hFF));
        drain();
        run_transfer(1'b0, 16'hFFFF, 16'h0000, 0);
        write_reg(CFG_TARGET, 16'h000F);
        write_reg(CFG_SOURCE, 16'hFFFF);
        run_transfer(1'b1, 16'h0000, 16'h0002, 0);
        write_reg(CFG_TIMEOUT, 16'h0001);
        run_transfer(1'b1, 16'hA5C3, 16'h0001, 1);
        run_transfer(1'b0, 16'h1234, 16'h0003, 2);
        write_reg(CFG_TIMEOUT, 16'hFFFF);
        run_transfer(1'b0, 16'h00FF, 16'h0002, 0);
        write_reg(CFG_TARGET, 16'h0000);
        write_reg(CFG_SOURCE, 16'h0000);
        write_reg(CFG_TIMEOUT, 16'd10);

        txn = 0;
        while (txn < 12)
        begin
            mode = (txn / 3) % 4;
            gap_pct = (mode == 1 || mode == 3) ? ((mode == 3) ? 12 : 51) : 0;
            stall_pct = (mode == 2 || mode == 3) ? ((mode == 3) ? 12 : 51) : 0;
            if ($urandom_range(3) == 0)
            begin
                mode = $urandom_range(2);
                if (mode == 2) write_reg(CFG_TIMEOUT, 16'($urandom_range(4, 20)));
                else write_reg(2'(mode), 16'($urandom_range(16'hFFFF)));
            end
            if ($urandom_range(3) == 0) cnt = $urandom_range(0, 1);
            else cnt = $urandom_range(0, 6);
            run_transfer(txn[0], 16'($urandom_range(16'hFFFF)), 16'(cnt),
                ($urandom_range(99) < 60) ? 0 : $urandom_range(1, 3));
            txn++;
        end
        gap_pct = 0;
        stall_pct = 0;
        drain();
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
